### rtl/frx_pkg.sv
`default_nettype none

package frx_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int IDX_W       = 5;
	localparam int STORE_DEPTH = 32;
	localparam int STORE_AW    = 5;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

	// result kinds
	localparam logic KIND_GOOD = 1'b0;
	localparam logic KIND_BAD  = 1'b1;

	// deframing phase, one-hot
	typedef enum logic [4:0] {
		PH_WAIT = 5'b00001,
		PH_HDR  = 5'b00010,
		PH_CMD  = 5'b00100,
		PH_PAY  = 5'b01000,
		PH_CHK  = 5'b10000
	} phase_t;

	// payload store write port
	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [BYTE_W-1:0]   data;
	} wr_t;

	// run request from deframer to readout
	typedef struct packed {
		logic              valid;
		logic              kind;
		logic              zero;
		logic [BYTE_W-1:0] command;
		logic [LEN_W-1:0]  length;
	} req_t;

	// readout status
	typedef struct packed {
		logic busy;
	} drain_stat_t;

endpackage

`default_nettype wire

### rtl/frx_store.sv
`default_nettype none

module frx_store
	import frx_pkg::*;
(
	input  wire logic                clk,
	input  wire wr_t                 wr,
	input  wire logic                rd_en,
	input  wire logic [STORE_AW-1:0] rd_addr,
	output logic      [BYTE_W-1:0]   rd_data
);

	logic [BYTE_W-1:0] mem_q [STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered read port, holds when not read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/frx_deframe.sv
`default_nettype none

module frx_deframe
	import frx_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 32
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              beat,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              line_error,
	input  wire logic [BYTE_W-1:0] header_byte,
	output wr_t                    wr,
	output req_t                   req
);

	localparam int LEN_LIMIT = (MAX_PAYLOAD_BYTES > STORE_DEPTH) ? STORE_DEPTH
	                                                              : MAX_PAYLOAD_BYTES;

	phase_t            phase_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  fill_q;
	logic [BYTE_W-1:0] xor_q;
	logic              take;
	logic [LEN_W-1:0]  fill_next;

	assign take      = beat && !line_error;
	assign fill_next = fill_q + LEN_W'(1);

	// payload bytes go straight into the store
	assign wr.en   = take && (phase_q == PH_PAY);
	assign wr.addr = fill_q[STORE_AW-1:0];
	assign wr.data = rx_byte;

	// checksum beat starts a readout run
	always_comb begin
		req.valid   = take && (phase_q == PH_CHK);
		req.kind    = (rx_byte == xor_q) ? KIND_GOOD : KIND_BAD;
		req.zero    = (rx_byte != xor_q) || (len_q == '0);
		req.command = cmd_q;
		req.length  = len_q;
	end

	// frame state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cmd_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			xor_q   <= '0;
		end else if (take) begin
			case (phase_q)
				PH_HDR: begin
					cmd_q   <= rx_byte;
					xor_q   <= xor_q ^ rx_byte;
					phase_q <= PH_CMD;
				end
				PH_CMD: begin
					xor_q  <= xor_q ^ rx_byte;
					fill_q <= '0;
					if (rx_byte > BYTE_W'(LEN_LIMIT)) begin
						phase_q <= PH_WAIT;
					end else begin
						len_q   <= rx_byte[LEN_W-1:0];
						phase_q <= (rx_byte == '0) ? PH_CHK : PH_PAY;
					end
				end
				PH_PAY: begin
					xor_q  <= xor_q ^ rx_byte;
					fill_q <= fill_next;
					if (fill_next >= len_q) begin
						phase_q <= PH_CHK;
					end
				end
				PH_CHK: begin
					phase_q <= PH_WAIT;
				end
				default: begin
					if (rx_byte == header_byte) begin
						phase_q <= PH_HDR;
						xor_q   <= '0;
					end else begin
						phase_q <= PH_WAIT;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/frx_drain.sv
`default_nettype none

module frx_drain
	import frx_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire req_t                req,
	output logic                     rd_en,
	output logic      [STORE_AW-1:0] rd_addr,
	input  wire logic [BYTE_W-1:0]   rd_data,
	output drain_stat_t              stat,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     out_kind,
	output logic      [BYTE_W-1:0]   out_command,
	output logic      [LEN_W-1:0]    out_length,
	output logic      [IDX_W-1:0]    out_index,
	output logic      [BYTE_W-1:0]   out_data,
	output logic                     out_last
);

	// run being issued
	logic              act_q;
	logic              kind_q;
	logic              zero_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  cnt_q;

	// read in flight, waiting for the output register
	logic              p_q;
	logic              p_kind_q;
	logic              p_zero_q;
	logic [BYTE_W-1:0] p_cmd_q;
	logic [LEN_W-1:0]  p_len_q;
	logic [IDX_W-1:0]  p_idx_q;
	logic              p_last_q;

	logic              o_q;
	logic              load;
	logic              issue;
	logic              is_last;
	logic [LEN_W-1:0]  cnt_next;

	assign load     = p_q && (!o_q || out_ready);
	assign issue    = act_q && (!p_q || load);
	assign cnt_next = cnt_q + LEN_W'(1);
	assign is_last  = zero_q || (cnt_next == len_q);
	assign rd_en    = issue && !zero_q;
	assign rd_addr  = cnt_q[STORE_AW-1:0];
	assign stat.busy = act_q;
	assign out_valid = o_q;

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.valid) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_next;
			if (is_last) begin
				act_q <= 1'b0;
			end
		end
	end

	// run descriptor
	always_ff @(posedge clk) begin
		if (req.valid) begin
			kind_q <= req.kind;
			zero_q <= req.zero;
			cmd_q  <= req.command;
			len_q  <= req.length;
		end
	end

	// in-flight and output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 1'b0;
			o_q <= 1'b0;
		end else begin
			if (issue) begin
				p_q <= 1'b1;
			end else if (load) begin
				p_q <= 1'b0;
			end
			if (load) begin
				o_q <= 1'b1;
			end else if (out_ready) begin
				o_q <= 1'b0;
			end
		end
	end

	// in-flight tag
	always_ff @(posedge clk) begin
		if (issue) begin
			p_kind_q <= kind_q;
			p_zero_q <= zero_q;
			p_cmd_q  <= cmd_q;
			p_len_q  <= len_q;
			p_idx_q  <= cnt_q[IDX_W-1:0];
			p_last_q <= is_last;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind    <= p_kind_q;
			out_command <= p_cmd_q;
			out_length  <= p_len_q;
			out_index   <= p_idx_q;
			out_data    <= p_zero_q ? '0 : rd_data;
			out_last    <= p_last_q;
		end
	end

endmodule

`default_nettype wire

### rtl/xor_checked_frame_receiver.sv
// Frame receiver for a byte stream of the form header, command, length,
// payload and an XOR checksum over command, length and payload.
// Slave stream: one received byte per beat, tuser flags a line error and
// such a beat is dropped without effect. Bytes that complete no frame
// give no result.
// Master stream: one beat per payload byte of a good frame (tlast on the
// final one), one beat for an empty frame, or one error beat (tuser high)
// on a checksum mismatch. An over-long length drops the frame silently.
// Payload is kept in a 32-entry store with a registered read port; after
// the checksum beat the run is read back at one entry a cycle while the
// master keeps up, each result passing the run sequencer, the store read
// and the output register. s_tready is low while the run is still being
// read, so a frame holds the input until its last payload byte (or its
// single-beat result) has been issued, and longer when the master stalls.
// Output is registered: when the master stalls, the last result and one
// read in flight are held and nothing is lost.
// Configuration: a write on cfg sets the header byte; the user must write it
// only while the block is idle, which the block does not enforce itself.
// Reset sets the header byte to 0xAA and waits for a header, no result pending.
`default_nettype none

module xor_checked_frame_receiver
	import frx_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 32
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	input  wire logic        s_tuser,   // line_error
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // command, length, byte_index, data, zero fill
	output logic             m_tuser,   // kind
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data   // header_byte
);

	logic [BYTE_W-1:0]   header_q;
	wr_t                 wr;
	req_t                req;
	drain_stat_t         stat;
	logic                rd_en;
	logic [STORE_AW-1:0] rd_addr;
	logic [BYTE_W-1:0]   rd_data;
	logic [BYTE_W-1:0]   o_cmd;
	logic [LEN_W-1:0]    o_len;
	logic [IDX_W-1:0]    o_idx;
	logic [BYTE_W-1:0]   o_data;

	assign cfg_ready = 1'b1;
	assign s_tready  = !stat.busy;

	// header byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			header_q <= cfg_data;
		end
	end

	frx_deframe #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_deframe (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (s_tvalid && s_tready),
		.rx_byte    (s_tdata),
		.line_error (s_tuser),
		.header_byte(header_q),
		.wr         (wr),
		.req        (req)
	);

	frx_store u_store (
		.clk    (clk),
		.wr     (wr),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	frx_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_command(o_cmd),
		.out_length (o_len),
		.out_index  (o_idx),
		.out_data   (o_data),
		.out_last   (m_tlast)
	);

	// result beat packing
	assign m_tdata = {5'b0, o_data, o_idx, o_len, o_cmd};

	// no payload write lands while a run is being read back
	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !stat.busy)
		else $error("payload write during readout run");

	// a new run only starts once the previous one is fully issued
	a_req_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !stat.busy)
		else $error("run request while readout busy");

	// an error result is a single zero beat
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (o_data == '0) && (o_idx == '0)))
		else $error("malformed checksum error beat");

endmodule

`default_nettype wire

### test/tb_xor_checked_frame_receiver.sv
`default_nettype none

module tb_xor_checked_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import frx_pkg::*;

	localparam int PAYLOAD_CAP = 32;
	localparam int LEN_LIMIT   = (PAYLOAD_CAP > STORE_DEPTH) ? STORE_DEPTH : PAYLOAD_CAP;
	localparam int PHASE_GAP   = 10;
	localparam int END_GAP     = 40;
	localparam int PHASE_ITEMS = 36;

	// one result beat, unpacked from the master stream
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] command;
		logic [LEN_W-1:0]  length;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
		logic              last;
	} frame_beat_t;

	// deframer prediction and result comparison
	class frame_scoreboard;
		logic [7:0]  header;
		phase_t      ph;
		logic [7:0]  cmd;
		logic [7:0]  run_xor;
		logic [5:0]  len;
		logic [5:0]  fill;
		logic [7:0]  store [STORE_DEPTH];
		frame_beat_t expected [$];
		int          errors;

		function new();
			header  = HEADER_RESET;
			ph      = PH_WAIT;
			cmd     = '0;
			run_xor = '0;
			len     = '0;
			fill    = '0;
			errors  = 0;
		endfunction

		function void push_beat(logic kind, logic [4:0] idx, logic [7:0] d, logic lst);
			frame_beat_t e;
			e.kind    = kind;
			e.command = cmd;
			e.length  = len;
			e.idx     = idx;
			e.data    = d;
			e.last    = lst;
			expected.push_back(e);
		endfunction

		function string describe(frame_beat_t r);
			return $sformatf("kind=%0d cmd=%h len=%0d idx=%0d data=%h last=%0d",
				r.kind, r.command, r.length, r.idx, r.data, r.last);
		endfunction

		// one accepted input beat
		function void note_byte(logic [7:0] b, logic err);
			if (err)
				return;
			case (ph)
			PH_HDR: begin
				cmd     = b;
				run_xor = run_xor ^ b;
				ph      = PH_CMD;
			end
			PH_CMD: begin
				run_xor = run_xor ^ b;
				fill    = '0;
				if (b > LEN_LIMIT) begin
					ph = PH_WAIT;
				end else begin
					len = b[5:0];
					ph  = (b == 8'd0) ? PH_CHK : PH_PAY;
				end
			end
			PH_PAY: begin
				store[fill[4:0]] = b;
				run_xor = run_xor ^ b;
				fill    = fill + 6'd1;
				if (fill >= len)
					ph = PH_CHK;
			end
			PH_CHK: begin
				if (b == run_xor) begin
					if (len == 6'd0) begin
						push_beat(KIND_GOOD, 5'd0, 8'd0, 1'b1);
					end else begin
						for (int i = 0; i < len; i++)
							push_beat(KIND_GOOD, 5'(i), store[i], (i + 1 == len));
					end
				end else begin
					push_beat(KIND_BAD, 5'd0, 8'd0, 1'b1);
				end
				ph = PH_WAIT;
			end
			default: begin
				if (b == header) begin
					ph      = PH_HDR;
					run_xor = '0;
				end else begin
					ph = PH_WAIT;
				end
			end
			endcase
		endfunction

		// one accepted result beat
		function void check_beat(logic tuser, logic [31:0] tdata, logic tlast);
			frame_beat_t got;
			frame_beat_t want;
			got.kind    = tuser;
			got.command = tdata[7:0];
			got.length  = tdata[13:8];
			got.idx     = tdata[18:14];
			got.data    = tdata[26:19];
			got.last    = tlast;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %s", $time, describe(got));
				return;
			end
			want = expected.pop_front();
			if (got.kind !== want.kind || got.command !== want.command ||
			    got.length !== want.length || got.idx !== want.idx ||
			    got.data !== want.data || got.last !== want.last) begin
				errors++;
				$display("%0t: mismatch, expected %s", $time, describe(want));
				$display("%0t:           actual   %s", $time, describe(got));
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;    // rx_byte
	logic        s_tuser   = 1'b0;    // line_error
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;             // command, length, byte_index, data, zero fill
	logic        m_tuser;             // kind
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = 8'd0;    // header_byte

	frame_scoreboard sb;
	int          src_idle  = 0;
	int          snk_stall = 0;
	int          fed       = 0;
	logic [7:0]  pay_buf [STORE_DEPTH];

	xor_checked_frame_receiver #(
		.MAX_PAYLOAD_BYTES(PAYLOAD_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	always #1 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall);
	end

	// result monitor, sampled mid-cycle
	always @(negedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_beat(m_tuser, m_tdata, m_tlast);
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [7:0] b, input logic err);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= err;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		sb.note_byte(b, err);
		if (!err)
			fed++;
	endtask

	// frame byte, sometimes preceded by a beat flagged with a line error
	task automatic send_noisy(input logic [7:0] b, input int err_pct);
		if ($urandom_range(99) < err_pct)
			send_beat(8'($urandom), 1'b1);
		send_beat(b, 1'b0);
	endtask

	// whole frame from pay_buf, checksum optionally corrupted
	task automatic send_frame(input logic [7:0] cmd, input int n, input bit bad,
	                          input int err_pct);
		logic [7:0] chk;
		chk = cmd ^ 8'(n);
		send_noisy(sb.header, err_pct);
		send_noisy(cmd, err_pct);
		send_noisy(8'(n), err_pct);
		for (int i = 0; i < n; i++) begin
			chk = chk ^ pay_buf[i];
			send_noisy(pay_buf[i], err_pct);
		end
		if (bad)
			chk = chk ^ (8'd1 << $urandom_range(7));
		send_noisy(chk, err_pct);
	endtask

	// wait for every expected result, then let the block settle
	task automatic settle(input int gap);
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (gap) @(posedge clk);
	endtask

	task automatic write_header(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		sb.header = v;
	endtask

	// random traffic under one idling pattern and one header value
	task automatic run_phase(input int src, input int snk, input logic [7:0] hdr,
	                         input int target);
		int start;
		int r;
		int n;
		src_idle  = src;
		snk_stall = snk;
		write_header(hdr);
		start = fed;
		while (fed - start < target) begin
			r = $urandom_range(99);
			if (r < 70) begin
				// well-formed frame, mostly short
				n = ($urandom_range(9) == 0) ? $urandom_range(7, LEN_LIMIT)
				                             : $urandom_range(0, 6);
				if ($urandom_range(19) == 0)
					n = LEN_LIMIT;
				for (int i = 0; i < n; i++)
					pay_buf[i] = ($urandom_range(7) == 0) ? sb.header : 8'($urandom);
				send_frame(8'($urandom), n, ($urandom_range(6) == 0), 8);
			end else if (r < 78) begin
				// length over the limit
				send_noisy(sb.header, 8);
				send_noisy(8'($urandom), 8);
				send_noisy(8'($urandom_range(LEN_LIMIT + 1, 255)), 8);
			end else if (r < 90) begin
				// line noise
				repeat ($urandom_range(1, 3))
					send_beat(8'($urandom), ($urandom_range(3) == 0));
			end else begin
				// truncated frame, the next bytes run on into it
				n = $urandom_range(1, 8);
				send_beat(sb.header, 1'b0);
				send_beat(8'($urandom), 1'b0);
				send_beat(8'(n), 1'b0);
				repeat ($urandom_range(0, n - 1))
					send_beat(8'($urandom), 1'b0);
			end
		end
		// close any open frame so the block is idle
		while (sb.ph != PH_WAIT)
			send_beat(8'($urandom), 1'b0);
		s_tvalid <= 1'b0;
		settle(PHASE_GAP);
	endtask

	// main sequence
	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise and a header beat flagged with a line error
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(HEADER_RESET, 1'b1);
		// empty frame
		send_frame(8'hFF, 0, 1'b0, 0);
		// checksum mismatch
		pay_buf[0] = 8'h55;
		send_frame(8'h00, 1, 1'b1, 0);
		// length one over the limit, then the largest length byte
		send_beat(HEADER_RESET, 1'b0);
		send_beat(8'h12, 1'b0);
		send_beat(8'(LEN_LIMIT + 1), 1'b0);
		send_beat(HEADER_RESET, 1'b0);
		send_beat(8'h34, 1'b0);
		send_beat(8'hFF, 1'b0);
		// header value inside a frame, line errors before every byte
		pay_buf[0] = HEADER_RESET;
		pay_buf[1] = 8'hFF;
		send_frame(HEADER_RESET, 2, 1'b0, 100);
		// longest frame
		for (int i = 0; i < LEN_LIMIT; i++)
			pay_buf[i] = 8'($urandom);
		pay_buf[0]             = 8'h00;
		pay_buf[LEN_LIMIT - 1] = 8'hFF;
		send_frame(8'($urandom), LEN_LIMIT, 1'b0, 0);
		s_tvalid <= 1'b0;
		settle(PHASE_GAP);

		// random phases
		run_phase(0, 0, 8'h00, PHASE_ITEMS);
		run_phase(77, 0, 8'hFF, PHASE_ITEMS);
		run_phase(0, 77, 8'($urandom_range(1, 254)), PHASE_ITEMS);
		run_phase(19, 19, HEADER_RESET, PHASE_ITEMS);

		settle(END_GAP);
		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/frx_pkg.sv
rtl/frx_store.sv
rtl/frx_deframe.sv
rtl/frx_drain.sv
rtl/xor_checked_frame_receiver.sv
test/tb_xor_checked_frame_receiver.sv
